// ===== sv/nrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared constants, codes and types of the node range table.
// ----------------------------------------------------------------------------
package nrt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int CMD_W = 3;
   localparam int ID_W  = 31;
   localparam int KEY_W = 64;
   localparam int ST_W  = 2;
   localparam int CFG_W = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   localparam logic [CMD_W-1:0] CMD_UPSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
   localparam logic [ST_W-1:0] ST_END       = 2'd3;

   typedef struct packed {
      logic load;
      logic search;
      logic pick;
      logic exec;
   } ctrl_cmd_type;

endpackage

// ===== sv/nrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrt_ctrl
// Sequencer: accept, search, pick, execute, present the response.
// ----------------------------------------------------------------------------
module nrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nrt_pkg::ctrl_cmd_type cmd
);
   import nrt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_PICK   = 3'd2;
   localparam logic [2:0] S_EXEC   = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SEARCH;
         S_SEARCH: state_in = S_PICK;
         S_PICK:   state_in = S_EXEC;
         S_EXEC:   state_in = S_OUT;
         S_OUT:    if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign cmd.load   = (state_ff == S_IDLE) && req_valid;
   assign cmd.search = (state_ff == S_SEARCH);
   assign cmd.pick   = (state_ff == S_PICK);
   assign cmd.exec   = (state_ff == S_EXEC);

endmodule

// ===== sv/nrt_datapath.sv =====
// ----------------------------------------------------------------------------
// nrt_datapath
// Slot storage, parallel id compare, priority pick and command execution.
// ----------------------------------------------------------------------------
module nrt_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  nrt_pkg::ctrl_cmd_type                  cmd,
   input  logic                                   csr_wr_en,
   input  logic        [nrt_pkg::CFG_W-1:0]       csr_wr_data,
   input  logic        [nrt_pkg::CMD_W-1:0]       req_command,
   input  logic        [nrt_pkg::ID_W-1:0]        req_node_id,
   input  logic signed [nrt_pkg::KEY_W-1:0]       req_key_start,
   input  logic signed [nrt_pkg::KEY_W-1:0]       req_key_end,
   output logic        [nrt_pkg::ST_W-1:0]        rsp_status,
   output logic        [nrt_pkg::ID_W-1:0]        rsp_found_node_id,
   output logic signed [nrt_pkg::KEY_W-1:0]       rsp_range_start,
   output logic signed [nrt_pkg::KEY_W-1:0]       rsp_range_end
);
   import nrt_pkg::*;

   function automatic logic [IDX_W-1:0] first_set(input logic [MAX_ENTRIES-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

   // transaction payload
   logic [CMD_W-1:0] cmd_ff;
   logic [ID_W-1:0]  id_ff;
   logic [KEY_W-1:0] ks_ff;
   logic [KEY_W-1:0] ke_ff;

   logic [CFG_W-1:0] cfg_ff;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] active_n;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]        node_ff [MAX_ENTRIES];
   logic [KEY_W-1:0]       kstart_mem [MAX_ENTRIES];
   logic [KEY_W-1:0]       kend_mem   [MAX_ENTRIES];

   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic [MAX_ENTRIES-1:0] free_ff, free_in;
   logic [MAX_ENTRIES-1:0] scan_ff, scan_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             hit_ff, hit_in;

   logic             wr_en;
   logic [ST_W-1:0]  status_ff, status_in;
   logic [ID_W-1:0]  rid_ff, rid_in;
   logic             show_ff, show_in;
   logic [KEY_W-1:0] rd_start_ff, rd_end_ff;

   always_comb begin
      if (int'(cfg_ff) > MAX_ENTRIES) active_n = CNT_W'(MAX_ENTRIES);
      else                            active_n = CNT_W'(cfg_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         id_ff  <= req_node_id;
         ks_ff  <= req_key_start;
         ke_ff  <= req_key_end;
      end
   end

   // search: one compare lane per slot
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (CNT_W'(i) < active_n) && (node_ff[i] == id_ff);
         free_in[i]  = !valid_ff[i] && (CNT_W'(i) < active_n);
         scan_in[i]  = valid_ff[i] && (CNT_W'(i) < active_n) && (CNT_W'(i) >= cursor_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         match_ff <= match_in;
         free_ff  <= free_in;
         scan_ff  <= scan_in;
      end
   end

   // pick: lowest-numbered candidate
   always_comb begin
      priority if (cmd_ff == CMD_NEXT) begin
         idx_in = first_set(scan_ff);
         hit_in = |scan_ff;
      end else if (cmd_ff == CMD_UPSERT && !(|match_ff)) begin
         idx_in = first_set(free_ff);
         hit_in = |free_ff;
      end else begin
         idx_in = first_set(match_ff);
         hit_in = |match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         idx_ff <= idx_in;
         hit_ff <= hit_in;
      end
   end

   // execute
   always_comb begin
      valid_in  = valid_ff;
      cursor_in = cursor_ff;
      wr_en     = 1'b0;
      status_in = ST_OK;
      rid_in    = '0;
      show_in   = 1'b0;
      unique case (cmd_ff)
         CMD_UPSERT: begin
            if (hit_ff) begin
               valid_in[idx_ff] = 1'b1;
               wr_en            = 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (hit_ff) valid_in[idx_ff] = 1'b0;
            else        status_in = ST_NOT_FOUND;
         end
         CMD_LOOKUP: begin
            if (hit_ff) show_in   = 1'b1;
            else        status_in = ST_NOT_FOUND;
         end
         CMD_START: begin
            cursor_in = '0;
         end
         CMD_NEXT: begin
            if (hit_ff) begin
               rid_in    = node_ff[idx_ff];
               show_in   = 1'b1;
               cursor_in = CNT_W'({1'b0, idx_ff}) + CNT_W'(1);
            end else begin
               status_in = ST_END;
               if (cursor_ff < active_n) cursor_in = active_n;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         cursor_ff <= '0;
         cfg_ff    <= CFG_RESET;
      end else begin
         if (cmd.exec) begin
            valid_ff  <= valid_in;
            cursor_ff <= cursor_in;
         end
         if (csr_wr_en) cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) node_ff[idx_ff] <= id_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) begin
            kstart_mem[idx_ff] <= ks_ff;
            kend_mem[idx_ff]   <= ke_ff;
         end
         rd_start_ff <= kstart_mem[idx_ff];
         rd_end_ff   <= kend_mem[idx_ff];
         status_ff   <= status_in;
         rid_ff      <= rid_in;
         show_ff     <= show_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_found_node_id = rid_ff;
   assign rsp_range_start   = show_ff ? rd_start_ff : '0;
   assign rsp_range_end     = show_ff ? rd_end_ff : '0;

endmodule

// ===== sv/node_range_table_top.sv =====
// ----------------------------------------------------------------------------
// node_range_table_top
// Associative table mapping a node id to a signed 64-bit key range.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready) carries a command (upsert, delete,
// lookup, start iteration, next entry) with node id and key range. Response
// channel (rsp_valid/rsp_ready) returns one transaction per request: status,
// node id (next only) and the stored range (lookup and next).
// The csr_ port writes the number of slots in use; write it only when idle.
// The response is valid once the request has passed the search lanes,
// the priority pick and the execute step with its key memory read.
// One transaction at a time: a new request is taken the cycle after the
// response is taken.
// A stalled response holds its payload and blocks further requests.
// Reset empties the table, clears the iteration cursor and sets the slot
// count to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module node_range_table_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic        [nrt_pkg::CMD_W-1:0] req_command,
   input  logic        [nrt_pkg::ID_W-1:0]  req_node_id,
   input  logic signed [nrt_pkg::KEY_W-1:0] req_key_start,
   input  logic signed [nrt_pkg::KEY_W-1:0] req_key_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic        [nrt_pkg::ST_W-1:0]  rsp_status,
   output logic        [nrt_pkg::ID_W-1:0]  rsp_found_node_id,
   output logic signed [nrt_pkg::KEY_W-1:0] rsp_range_start,
   output logic signed [nrt_pkg::KEY_W-1:0] rsp_range_end,
   input  logic                             csr_wr_en,
   input  logic        [nrt_pkg::CFG_W-1:0] csr_wr_data
);
   import nrt_pkg::*;

   ctrl_cmd_type cmd;

   nrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   nrt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_command       (req_command),
      .req_node_id       (req_node_id),
      .req_key_start     (req_key_start),
      .req_key_end       (req_key_end),
      .rsp_status        (rsp_status),
      .rsp_found_node_id (rsp_found_node_id),
      .rsp_range_start   (rsp_range_start),
      .rsp_range_end     (rsp_range_end)
   );

endmodule
